// ===== src/bte_pkg.sv =====
// Shared types, constants and the month table for the BCD time to epoch seconds core.
package bte_pkg;

  // Register masks applied before BCD decoding
  localparam logic [7:0] SecMask  = 8'h7F;
  localparam logic [7:0] MinMask  = 8'h7F;
  localparam logic [7:0] HourMask = 8'h3F;
  localparam logic [7:0] WdayMask = 8'h07;
  localparam logic [7:0] DateMask = 8'h3F;
  localparam logic [7:0] MonMask  = 8'h1F;

  localparam int unsigned DaysW = 17;  // day count incl. the minus-one wrap
  localparam int unsigned TodW  = 18;  // seconds within the (unchecked) day

  localparam logic [11:0] YearBase    = 12'd2000;
  localparam logic [DaysW-1:0] DaysPerYear = 17'd365;
  localparam logic [TodW-1:0] SecPerHour   = 18'd3600;
  localparam logic [TodW-1:0] SecPerMin    = 18'd60;
  localparam logic [31:0] SecPerDay        = 32'd86400;
  localparam logic [3:0] MaxFullMonths     = 4'd12;

  // Decoded fields of one snapshot, carried down the pipeline
  typedef struct packed {
    logic [6:0] sec;
    logic [6:0] min;
    logic [5:0] hour;
    logic [2:0] wday;
    logic [5:0] day;
    logic [4:0] mon;
    logic [7:0] yy;
  } fields_t;

  // Packed BCD: high nibble times ten plus low nibble, non-BCD nibbles as they are
  function automatic logic [7:0] bcd_decode(input logic [7:0] b);
    logic [7:0] hi;
    logic [7:0] lo;
    hi = {4'd0, b[7:4]};
    lo = {4'd0, b[3:0]};
    return 8'((hi << 3) + (hi << 1) + lo);
  endfunction

  // Days before the first of the month after the given number of whole months
  function automatic logic [8:0] month_start_days(input logic [3:0] full_months);
    logic [8:0] d;
    case (full_months)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd365;
    endcase
    return d;
  endfunction

endpackage

// ===== src/bte_days.sv =====
// Day count since 2000-01-01 from decoded year, month and day of month.
module bte_days (
  input  logic [7:0]               yy_i,
  input  logic [4:0]               mon_i,
  input  logic [5:0]               day_i,
  output logic [bte_pkg::DaysW-1:0] days_o
);

  logic [3:0]               full_months;
  logic                     leap;
  logic [bte_pkg::DaysW-1:0] year_days;
  logic [bte_pkg::DaysW-1:0] leap_days;
  logic [bte_pkg::DaysW-1:0] sum;

  // Whole months before this one, months above twelve count as a full year
  always_comb begin
    if (mon_i == 5'd0) begin
      full_months = 4'd0;
    end else if ((mon_i - 5'd1) > 5'(bte_pkg::MaxFullMonths)) begin
      full_months = bte_pkg::MaxFullMonths;
    end else begin
      full_months = 4'(mon_i - 5'd1);
    end
  end

  // Every year divisible by four is a leap year
  assign leap      = (yy_i[1:0] == 2'b00);
  assign year_days = bte_pkg::DaysW'(yy_i) * bte_pkg::DaysPerYear;
  assign leap_days = bte_pkg::DaysW'((9'(yy_i) + 9'd3) >> 2);

  // Day zero wraps to all ones, read as minus one downstream
  always_comb begin
    sum = year_days + leap_days
        + bte_pkg::DaysW'(bte_pkg::month_start_days(full_months))
        + bte_pkg::DaysW'(leap && (full_months >= 4'd2))
        + bte_pkg::DaysW'(day_i);
    days_o = sum - bte_pkg::DaysW'(1);
  end

endmodule

// ===== src/bcd_time_to_epoch_seconds_core.sv =====
// Top level: four-stage pipeline from raw BCD clock registers to seconds since 2000.
//
// Takes one raw clock snapshot per cycle and returns the decoded fields plus
// the seconds since 2000-01-01 00:00:00 (every year divisible by four is a
// leap year, result modulo 2^32). Each item passes through these registered
// stages in order: BCD decode, day count and time-of-day sum, days times
// 86400 (the 32-bit multiplier sets the stage depth), final add into the
// output register. Throughput is one item per cycle; a stall at the output
// holds every stage in place and input ready drops only once all four are full.
module bcd_time_to_epoch_seconds_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  seconds_bcd_i,
  input  logic [7:0]  minutes_bcd_i,
  input  logic [7:0]  hours_bcd_i,
  input  logic [7:0]  weekday_bcd_i,
  input  logic [7:0]  date_bcd_i,
  input  logic [7:0]  month_bcd_i,
  input  logic [7:0]  year_bcd_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] epoch_seconds_o,
  output logic [6:0]  second_value_o,
  output logic [6:0]  minute_value_o,
  output logic [5:0]  hour_value_o,
  output logic [2:0]  weekday_value_o,
  output logic [5:0]  day_value_o,
  output logic [4:0]  month_value_o,
  output logic [11:0] year_value_o
);

  logic v1_q, v2_q, v3_q, v4_q;
  logic v1_d, v2_d, v3_d, v4_d;
  logic en1, en2, en3, en4;

  bte_pkg::fields_t f1_q, f2_q, f3_q, f4_q;
  bte_pkg::fields_t f1_d;
  logic [bte_pkg::DaysW-1:0] days_d, days_q;
  logic [bte_pkg::TodW-1:0]  tod_d, tod2_q, tod3_q;
  logic [31:0]               prod_d, prod_q;
  logic [31:0]               secs_d, secs_q;

  // Stage enables: a stage moves when it is empty or its successor moves
  assign en4 = !v4_q || out_ready_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_ready_o = en1;

  assign v1_d = en1 ? in_valid_i : v1_q;
  assign v2_d = en2 ? v1_q : v2_q;
  assign v3_d = en3 ? v2_q : v3_q;
  assign v4_d = en4 ? v3_q : v4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
      v4_q <= v4_d;
    end
  end

  // Stage 1: mask and BCD-decode the register bytes; the weekday is only masked, the year only decoded
  always_comb begin
    f1_d.sec  = 7'(bte_pkg::bcd_decode(seconds_bcd_i & bte_pkg::SecMask));
    f1_d.min  = 7'(bte_pkg::bcd_decode(minutes_bcd_i & bte_pkg::MinMask));
    f1_d.hour = 6'(bte_pkg::bcd_decode(hours_bcd_i & bte_pkg::HourMask));
    f1_d.wday = 3'(weekday_bcd_i & bte_pkg::WdayMask);
    f1_d.day  = 6'(bte_pkg::bcd_decode(date_bcd_i & bte_pkg::DateMask));
    f1_d.mon  = 5'(bte_pkg::bcd_decode(month_bcd_i & bte_pkg::MonMask));
    f1_d.yy   = bte_pkg::bcd_decode(year_bcd_i);
  end

  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      f1_q <= f1_d;
    end
  end

  // Stage 2: day count and seconds within the day
  bte_days u_days (
    .yy_i   (f1_q.yy),
    .mon_i  (f1_q.mon),
    .day_i  (f1_q.day),
    .days_o (days_d)
  );

  assign tod_d = bte_pkg::TodW'(f1_q.hour) * bte_pkg::SecPerHour
               + bte_pkg::TodW'(f1_q.min) * bte_pkg::SecPerMin
               + bte_pkg::TodW'(f1_q.sec);

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      f2_q   <= f1_q;
      days_q <= days_d;
      tod2_q <= tod_d;
    end
  end

  // Stage 3: days to seconds, the day count sign-extended so day zero wraps
  assign prod_d = {{(32 - bte_pkg::DaysW){days_q[bte_pkg::DaysW-1]}}, days_q}
                * bte_pkg::SecPerDay;

  always_ff @(posedge clk_i) begin
    if (en3 && v2_q) begin
      f3_q   <= f2_q;
      prod_q <= prod_d;
      tod3_q <= tod2_q;
    end
  end

  // Stage 4: final sum into the output register
  assign secs_d = prod_q + 32'(tod3_q);

  always_ff @(posedge clk_i) begin
    if (en4 && v3_q) begin
      f4_q   <= f3_q;
      secs_q <= secs_d;
    end
  end

  assign out_valid_o     = v4_q;
  assign epoch_seconds_o = secs_q;
  assign second_value_o  = f4_q.sec;
  assign minute_value_o  = f4_q.min;
  assign hour_value_o    = f4_q.hour;
  assign weekday_value_o = f4_q.wday;
  assign day_value_o     = f4_q.day;
  assign month_value_o   = f4_q.mon;
  assign year_value_o    = bte_pkg::YearBase + 12'(f4_q.yy);

  // Full pipeline with a stalled output takes no new item
  a_full_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && v2_q && v3_q && v4_q && !out_ready_i) |-> !in_ready_o)
    else $error("input taken while pipeline full and stalled");

  // An accepted item always lands in the first stage
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> v1_q)
    else $error("accepted item lost at stage one");

  // A stalled result keeps its epoch value
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(epoch_seconds_o)))
    else $error("stalled result changed");

endmodule
